/* rtl/core/gbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_pkg
// Types and constants shared by the GBM price path step controller and
// datapath.
// ----------------------------------------------------------------------------
package gbm_pkg;

	// fixed point constants
	localparam logic [29:0] ONE_Q28   = 30'd268435456;
	localparam logic [27:0] LN2_Q28   = 28'd186065279;
	localparam logic [47:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;
	// bias that makes the exponent nonnegative before the ln2 reduction
	localparam int          K_BIAS    = 1024;
	localparam logic [39:0] X_OFFSET  = 40'(K_BIAS) * 40'(LN2_Q28);
	// floor(2^40 / ln2_q28), quotient estimate from the top exponent bits
	localparam logic [12:0] LN2_RECIP = 13'd5909;
	localparam logic [3:0]  EXP_TERMS = 4'd12;

	// configuration register indexes
	localparam logic [7:0] CFG_DRIFT_SPREAD   = 8'd0;
	localparam logic [7:0] CFG_VOLATILITY     = 8'd1;
	localparam logic [7:0] CFG_STEP_TIME      = 8'd2;
	localparam logic [7:0] CFG_ROOT_STEP_TIME = 8'd3;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_SUM,
		ST_MHI,
		ST_MLO,
		ST_DIFF,
		ST_XQ,
		ST_QE,
		ST_QM,
		ST_REM,
		ST_CORR,
		ST_EMUL,
		ST_EREC,
		ST_EFIX,
		ST_PHI,
		ST_PLO,
		ST_MSUM,
		ST_DONE
	} state_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ,
		OP_SUM,
		OP_MHI,
		OP_MLO,
		OP_DIFF,
		OP_XQ,
		OP_QE,
		OP_QM,
		OP_REM,
		OP_CORR,
		OP_EMUL,
		OP_EREC,
		OP_EFIX,
		OP_PHI,
		OP_PLO,
		OP_MSUM,
		OP_STORE
	} op_t;

	typedef struct packed {
		op_t op;
	} gbm_cmd_t;

	typedef struct packed {
		logic r_ge;
		logic n_last;
	} gbm_status_t;

	// floor(2^32 / n) for the series divisors
	function automatic logic [32:0] term_recip(input logic [3:0] n);
		logic [32:0] v;
		unique case (n)
			4'd1:    v = 33'd4294967296;
			4'd2:    v = 33'd2147483648;
			4'd3:    v = 33'd1431655765;
			4'd4:    v = 33'd1073741824;
			4'd5:    v = 33'd858993459;
			4'd6:    v = 33'd715827882;
			4'd7:    v = 33'd613566756;
			4'd8:    v = 33'd536870912;
			4'd9:    v = 33'd477218588;
			4'd10:   v = 33'd429496729;
			4'd11:   v = 33'd390451572;
			4'd12:   v = 33'd357913941;
			default: v = 33'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/gbm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_ctrl
// Sequencer for one price step: steps the datapath through the exponent,
// range reduction, exp series and price product, and owns the output valid.
// ----------------------------------------------------------------------------
module gbm_ctrl
	import gbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output gbm_cmd_t         cmd,
	input  wire gbm_status_t status
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   store;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign store    = (state_q == ST_DONE) && out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (store) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SQ;
				end
			end
			ST_SQ:   begin cmd.op = OP_SQ;   state_d = ST_SUM;  end
			ST_SUM:  begin cmd.op = OP_SUM;  state_d = ST_MHI;  end
			ST_MHI:  begin cmd.op = OP_MHI;  state_d = ST_MLO;  end
			ST_MLO:  begin cmd.op = OP_MLO;  state_d = ST_DIFF; end
			ST_DIFF: begin cmd.op = OP_DIFF; state_d = ST_XQ;   end
			ST_XQ:   begin cmd.op = OP_XQ;   state_d = ST_QE;   end
			ST_QE:   begin cmd.op = OP_QE;   state_d = ST_QM;   end
			ST_QM:   begin cmd.op = OP_QM;   state_d = ST_REM;  end
			ST_REM:  begin cmd.op = OP_REM;  state_d = ST_CORR; end
			ST_CORR: begin
				if (status.r_ge) begin
					cmd.op = OP_CORR;
				end else begin
					state_d = ST_EMUL;
				end
			end
			ST_EMUL: begin cmd.op = OP_EMUL; state_d = ST_EREC; end
			ST_EREC: begin cmd.op = OP_EREC; state_d = ST_EFIX; end
			ST_EFIX: begin
				cmd.op  = OP_EFIX;
				state_d = status.n_last ? ST_PHI : ST_EMUL;
			end
			ST_PHI:  begin cmd.op = OP_PHI;  state_d = ST_PLO;  end
			ST_PLO:  begin cmd.op = OP_PLO;  state_d = ST_MSUM; end
			ST_MSUM: begin cmd.op = OP_MSUM; state_d = ST_DONE; end
			ST_DONE: begin
				if (out_free) begin
					cmd.op  = OP_STORE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SQ))
		else $error("accepted item did not start the sequence");
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result stored over a pending output");
	a_corr_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORR && !status.r_ge) |=> (state_q == ST_EMUL))
		else $error("reduction correction did not exit");
	a_store_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		store |=> out_valid_q)
		else $error("stored result not presented");
`endif

endmodule
`default_nettype wire

/* rtl/core/gbm_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_dp
// Datapath for one price step: configuration registers, exponent terms,
// ln2 range reduction, exp series, price product, saturation and output.
// ----------------------------------------------------------------------------
module gbm_dp
	import gbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [95:0] in_data,
	input  wire logic        in_first,
	input  wire logic        in_last,
	input  wire gbm_cmd_t    cmd,
	output gbm_status_t      status,
	output logic [47:0]      out_price,
	output logic             out_overflowed,
	output logic             out_path_end
);

	// configuration
	logic [31:0] drift_spread_q, volatility_q, step_time_q, root_step_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_spread_q   <= '0;
			volatility_q     <= '0;
			step_time_q      <= '0;
			root_step_time_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DRIFT_SPREAD:   drift_spread_q   <= cfg_data;
				CFG_VOLATILITY:     volatility_q     <= cfg_data;
				CFG_STEP_TIME:      step_time_q      <= cfg_data;
				CFG_ROOT_STEP_TIME: root_step_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// path state
	logic [47:0] price_q;
	logic        ovf_q;

	// working registers
	logic [15:0] shock_q;
	logic [31:0] rate_q;
	logic        last_q;
	logic [63:0] sq_q, vp_q;
	logic        s_neg_q;
	logic [36:0] mag_q;
	logic [52:0] mh_q, ml_q;
	logic [37:0] drift_q;
	logic [47:0] dfm_q;
	logic [39:0] a_q, qm_q, r_q;
	logic [27:0] qe_q;
	logic [11:0] q_q;
	logic [29:0] t_q, y_q;
	logic [3:0]  n_q;
	logic [57:0] rt_q;
	logic [62:0] yr_q;
	logic [53:0] ph_q, pl_q;
	logic [50:0] m_q;
	logic [47:0] out_price_q;
	logic        out_ovf_q, out_last_q;

	// combinational terms
	logic [36:0] s_sum;
	logic [36:0] dmag;
	logic [37:0] drift_d, diff_d;
	logic [15:0] smag;
	logic [38:0] x_sum;
	logic [39:0] a_d;
	logic [30:0] qd_est;
	logic [34:0] qd_prod;
	logic [34:0] qd_rem;
	logic [30:0] qd_fix;
	logic [54:0] low_part;
	logic [50:0] m_d;
	logic [12:0] k_val;
	logic [12:0] k_neg_amt;
	logic [47:0] lim;
	logic [50:0] shr;
	logic [47:0] res;
	logic        sat;

	assign status.r_ge   = (r_q >= 40'(LN2_Q28));
	assign status.n_last = (n_q == 4'd1);

	// exponent drift and diffusion terms
	always_comb begin
		s_sum   = {{5{rate_q[31]}}, rate_q} + {{5{drift_spread_q[31]}}, drift_spread_q}
			- {2'b00, sq_q[63:29]};
		dmag    = 37'((mh_q + 53'(ml_q >> 16)) >> 16);
		drift_d = s_neg_q ? (38'd0 - {1'b0, dmag}) : {1'b0, dmag};
		smag    = shock_q[15] ? (16'd0 - shock_q) : shock_q;
		diff_d  = shock_q[15] ? (38'd0 - {2'b00, dfm_q[47:12]}) : {2'b00, dfm_q[47:12]};
		x_sum   = {drift_q[37], drift_q} + {diff_d[37], diff_d};
		a_d     = {x_sum[38], x_sum} + X_OFFSET;
	end

	// series term quotient with a one step correction
	always_comb begin
		qd_est  = yr_q[62:32];
		qd_prod = 35'(qd_est) * 35'(n_q);
		qd_rem  = {5'd0, y_q} - qd_prod;
		qd_fix  = (qd_rem >= 35'(n_q)) ? (qd_est + 31'd1) : qd_est;
	end

	// price product, scaling by 2^k and saturation
	always_comb begin
		low_part  = {ph_q[3:0], 24'd0} + {1'b0, pl_q};
		m_d       = 51'(ph_q >> 4) + 51'(low_part >> 28);
		k_val     = {1'b0, q_q} - 13'(K_BIAS);
		k_neg_amt = 13'd0 - k_val;
		lim       = PRICE_MAX >> k_val[5:0];
		shr       = m_q >> k_neg_amt[5:0];
		res       = '0;
		sat       = 1'b0;
		if (!k_val[12]) begin
			if (m_q == '0) begin
				res = '0;
			end else if (k_val >= 13'd48 || m_q > 51'(lim)) begin
				res = PRICE_MAX;
				sat = 1'b1;
			end else begin
				res = 48'(m_q << k_val[5:0]);
			end
		end else if (k_neg_amt >= 13'd51) begin
			res = '0;
		end else if (shr > 51'(PRICE_MAX)) begin
			res = PRICE_MAX;
			sat = 1'b1;
		end else begin
			res = shr[47:0];
		end
	end

	// path state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.op == OP_LOAD && in_first) begin
			price_q <= in_data[95:48];
			ovf_q   <= 1'b0;
		end else if (cmd.op == OP_STORE) begin
			price_q <= res;
			ovf_q   <= ovf_q | sat;
		end
	end

	// working registers per operation
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				shock_q <= in_data[15:0];
				rate_q  <= in_data[47:16];
				last_q  <= in_last;
				t_q     <= ONE_Q28;
				n_q     <= EXP_TERMS;
			end
			OP_SQ:   sq_q <= volatility_q * volatility_q;
			OP_SUM: begin
				s_neg_q <= s_sum[36];
				mag_q   <= s_sum[36] ? (37'd0 - s_sum) : s_sum;
				vp_q    <= volatility_q * root_step_time_q;
			end
			OP_MHI:  mh_q <= 53'(mag_q) * 53'(step_time_q[31:16]);
			OP_MLO:  ml_q <= 53'(mag_q) * 53'(step_time_q[15:0]);
			OP_DIFF: begin
				drift_q <= drift_d;
				dfm_q   <= 48'(vp_q[63:32]) * 48'(smag);
			end
			OP_XQ:   a_q  <= a_d;
			OP_QE:   qe_q <= 28'(a_q[38:24]) * 28'(LN2_RECIP);
			OP_QM: begin
				q_q  <= qe_q[27:16];
				qm_q <= 40'(qe_q[27:16]) * 40'(LN2_Q28);
			end
			OP_REM:  r_q <= a_q - qm_q;
			OP_CORR: begin
				r_q <= r_q - 40'(LN2_Q28);
				q_q <= q_q + 12'd1;
			end
			OP_EMUL: rt_q <= 58'(r_q[27:0]) * 58'(t_q);
			OP_EREC: begin
				y_q  <= rt_q[57:28];
				yr_q <= 63'(rt_q[57:28]) * 63'(term_recip(n_q));
			end
			OP_EFIX: begin
				t_q <= ONE_Q28 + qd_fix[29:0];
				n_q <= n_q - 4'd1;
			end
			OP_PHI:  ph_q <= 54'(price_q[47:24]) * 54'(t_q);
			OP_PLO:  pl_q <= 54'(price_q[23:0]) * 54'(t_q);
			OP_MSUM: m_q  <= m_d;
			OP_STORE: begin
				out_price_q <= res;
				out_ovf_q   <= ovf_q | sat;
				out_last_q  <= last_q;
			end
			OP_NONE: ;
			default: ;
		endcase
	end

	assign out_price      = out_price_q;
	assign out_overflowed = out_ovf_q;
	assign out_path_end   = out_last_q;

`ifndef NO_ASSERTIONS
	a_terms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMUL) |-> (n_q != 4'd0 && n_q <= EXP_TERMS))
		else $error("series term count out of range");
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMUL) |-> (r_q < 40'(LN2_Q28)))
		else $error("exponent remainder not reduced");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STORE && sat) |=> (out_price_q == PRICE_MAX && out_ovf_q))
		else $error("saturated result not at maximum");
`endif

endmodule
`default_nettype wire

/* rtl/core/gbm_price_path_step.sv */
`default_nettype none
// Each item runs serially through the exponent terms, the ln2 range reduction, the
// twelve term exp series and the price product; the reduction repeats its correction
// step while the remainder is at least ln2. One item in flight: a new item is taken
// only after the last result is stored, and a finished result waits for the previous
// one to leave. The output register holds a finished result while the next item is
// taken. Asynchronous reset clears state, valid, configuration, price and flag.
// ----------------------------------------------------------------------------
// gbm_price_path_step
// One exact geometric Brownian motion step per item: price times
// exp(drift*dt + sigma*sqrt(dt)*shock), saturating at the 48-bit maximum.
// ----------------------------------------------------------------------------
module gbm_price_path_step
	import gbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // shock[15:0], rate[47:16], start_price[95:48]
	input  wire logic        s_tuser,  // first_step
	input  wire logic        s_tlast,  // last_step
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // price[47:0]
	output logic             m_tuser,  // overflowed
	output logic             m_tlast   // path_end
);

	gbm_cmd_t    cmd;
	gbm_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	gbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// arithmetic
	gbm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_data        (s_tdata),
		.in_first       (s_tuser),
		.in_last        (s_tlast),
		.cmd            (cmd),
		.status         (status),
		.out_price      (m_tdata),
		.out_overflowed (m_tuser),
		.out_path_end   (m_tlast)
	);

endmodule
`default_nettype wire
